// ----- rtl/o2ae_pkg.sv -----
// Package for the order-2 arithmetic encoder: sizes, codes and sequencer states.
// No dependencies.
`default_nettype none
package o2ae_pkg;
  localparam int SYMBOLS   = 8;
  localparam int SYM_W     = 3;
  localparam int TBL_DEPTH = SYMBOLS * SYMBOLS * SYMBOLS;
  localparam int TBL_AW    = 3 * SYM_W;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ENCODE = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  localparam logic [1:0] OK_RUN = 2'd0;
  localparam logic [1:0] OK_RAW = 2'd1;
  localparam logic [1:0] OK_PAD = 2'd2;

  localparam logic [31:0] TOP_BIT    = 32'h8000_0000;
  localparam logic [31:0] SECOND_BIT = 32'h4000_0000;
  localparam logic [31:0] LOW_MASK   = 32'h3fff_ffff;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_SUM, ST_CHECK, ST_MUL, ST_DIV, ST_UPD,
    ST_NORM, ST_OUT, ST_FLUSH_PAD
  } state_t;
endpackage
`default_nettype wire

// ----- rtl/order2_arithmetic_encoder.sv -----
// Top level of the order-2 arithmetic encoder: count table, shared divider, renormalizer.
// Depends on o2ae_pkg.
//
// channel | dir | tdata                                          | tuser / tlast
// in_     | in  | [1:0] kind [4:2] ctx_older [7:5] ctx_newer      | -
//         |     | [10:8] symbol [42:11] count                     |
// out_    | out | [1:0] out_kind [2] lead_bit [34:3] follow_count | tlast = last
//         |     | [42:35] raw_byte [45:43] pad_count [46] error   |
//
// Load writes one table entry. Coded encode reads SYMBOLS table entries and runs two
// 64-bit restoring divisions on one shared subtractor, then renormalizes and emits its
// result beats.
// After reset a clearing pass writes zero to all TBL_DEPTH (512) entries.
// in_tready is low while an item is in work; each result waits for out_tready.
`default_nettype none
module order2_arithmetic_encoder
  import o2ae_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // kind, context_older, context_newer, symbol, count
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // out_kind, lead_bit, follow_count, raw_byte,
                                       // pad_count, error
  output logic             out_tlast
);
  logic [31:0] mem [TBL_DEPTH];
  logic [31:0] rd_q;
  logic [TBL_AW-1:0] rd_a;
  logic        we;
  logic [TBL_AW-1:0] wa;
  logic [31:0] wd;

  state_t st_r, st_nxt;
  logic [TBL_AW:0] clr_r, clr_nxt;
  logic [31:0] lo_r, lo_nxt, hi_r, hi_nxt, pend_r, pend_nxt;
  logic [SYM_W-1:0] ho_r, ho_nxt, hn_r, hn_nxt, sym_r, sym_nxt, idx_r, idx_nxt;
  logic [1:0]  raw_r, raw_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic [32:0] below_r, below_nxt, tot_r, tot_nxt;
  logic [31:0] own_r, own_nxt;
  logic [SYM_W:0] rdcnt_r, rdcnt_nxt;
  logic        pass_r, pass_nxt;     // 0: high quotient, 1: low quotient
  logic [63:0] dvd_r, dvd_nxt;       // dividend / quotient shift register
  logic [32:0] rem_r, rem_nxt;
  logic [6:0]  dcnt_r, dcnt_nxt;
  logic [63:0] qhi_r, qhi_nxt;
  logic [5:0]  ncnt_r, ncnt_nxt;
  logic        ov_r, ov_nxt;
  logic [47:0] od_r, od_nxt;
  logic        ol_r, ol_nxt;
  state_t      ret_r, ret_nxt;       // state after the result beat is taken

  logic [1:0]  i_kind;
  logic [SYM_W-1:0] i_old, i_new, i_sym;
  logic [31:0] i_cnt;
  assign i_kind = in_tdata[1:0];
  assign i_old  = in_tdata[4:2];
  assign i_new  = in_tdata[7:5];
  assign i_sym  = in_tdata[10:8];
  assign i_cnt  = in_tdata[42:11];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[rd_a];
  end

  function automatic logic [47:0] pack(input logic [1:0] k, input logic lb,
                                       input logic [31:0] fc, input logic [7:0] rb,
                                       input logic [2:0] pc, input logic er);
    pack = {1'b0, er, pc, rb, fc, lb, k};
  endfunction

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic [31:0] range32;
  logic [63:0] prod;
  logic [31:0] pend_inc;

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; lo_nxt = lo_r; hi_nxt = hi_r; pend_nxt = pend_r;
    ho_nxt = ho_r; hn_nxt = hn_r; sym_nxt = sym_r; idx_nxt = idx_r; raw_nxt = raw_r;
    ph_nxt = ph_r; below_nxt = below_r; tot_nxt = tot_r; own_nxt = own_r;
    rdcnt_nxt = rdcnt_r; pass_nxt = pass_r; dvd_nxt = dvd_r; rem_nxt = rem_r;
    dcnt_nxt = dcnt_r; qhi_nxt = qhi_r; ncnt_nxt = ncnt_r; ov_nxt = ov_r;
    od_nxt = od_r; ol_nxt = ol_r; ret_nxt = ret_r;
    we = 1'b0; wa = clr_r[TBL_AW-1:0]; wd = '0;
    rd_a = {ho_r, hn_r, idx_r};
    in_tready = 1'b0;
    range32 = hi_r - lo_r;
    prod = '0;
    rem_sh = {rem_r[31:0], dvd_r[63]};
    rem_sub = rem_sh - tot_r;
    pend_inc = (pend_r == 32'hffff_ffff) ? pend_r : pend_r + 32'd1;
    unique case (st_r)
      ST_CLEAR: begin
        we = 1'b1;
        clr_nxt = clr_r + (TBL_AW+1)'(1);
        if (clr_r == (TBL_AW+1)'(TBL_DEPTH - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          sym_nxt = i_sym;
          unique case (i_kind)
            KIND_LOAD: begin
              we = 1'b1; wa = {i_old, i_new, i_sym}; wd = i_cnt;
            end
            KIND_ENCODE: begin
              if (raw_r < 2'd2) begin
                ho_nxt = hn_r; hn_nxt = i_sym; raw_nxt = raw_r + 2'd1;
                od_nxt = pack(OK_RAW, 1'b0, '0, {5'd0, i_sym}, '0, 1'b0);
                ol_nxt = 1'b1; ret_nxt = ST_IDLE; st_nxt = ST_OUT;
              end else begin
                idx_nxt = '0; rdcnt_nxt = '0; below_nxt = '0; tot_nxt = '0;
                own_nxt = '0; st_nxt = ST_RD;
              end
            end
            KIND_FLUSH: begin
              od_nxt = pack(OK_RUN, lo_r[30], pend_inc, '0, '0, 1'b0);
              ph_nxt = ph_r + 3'd1 + pend_inc[2:0];
              ol_nxt = 1'b0; ret_nxt = ST_FLUSH_PAD; st_nxt = ST_OUT;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        idx_nxt = idx_r + SYM_W'(1);
        st_nxt = ST_SUM;
      end
      ST_SUM: begin
        // rd_q holds entry rdcnt_r
        tot_nxt = tot_r + {1'b0, rd_q};
        if (rdcnt_r[SYM_W-1:0] < sym_r) below_nxt = below_r + {1'b0, rd_q};
        if (rdcnt_r[SYM_W-1:0] == sym_r) own_nxt = rd_q;
        rdcnt_nxt = rdcnt_r + (SYM_W+1)'(1);
        if (rdcnt_r == (SYM_W+1)'(SYMBOLS - 1)) st_nxt = ST_CHECK;
        else begin
          idx_nxt = idx_r + SYM_W'(1);
        end
      end
      ST_CHECK: begin
        if (own_r == '0 || tot_r > 33'h0_ffff_fffe) begin
          od_nxt = pack(OK_RUN, 1'b0, '0, '0, '0, 1'b1);
          ol_nxt = 1'b1; ret_nxt = ST_IDLE; st_nxt = ST_OUT;
        end else begin
          pass_nxt = 1'b0; st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod = ({32'd0, range32} + 64'd1) *
               (pass_r ? {31'd0, below_r} : {31'd0, below_r + {1'b0, own_r}});
        dvd_nxt = prod; rem_nxt = '0; dcnt_nxt = '0; st_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!rem_sub[32]) begin
          rem_nxt = rem_sub; dvd_nxt = {dvd_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh; dvd_nxt = {dvd_r[62:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 7'd1;
        if (dcnt_r == 7'd63) begin
          if (!pass_r) begin
            qhi_nxt = dvd_nxt; pass_nxt = 1'b1; st_nxt = ST_MUL;
          end else st_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (qhi_r == dvd_r) begin
          od_nxt = pack(OK_RUN, 1'b0, '0, '0, '0, 1'b1);
          ol_nxt = 1'b1; ret_nxt = ST_IDLE; st_nxt = ST_OUT;
        end else begin
          hi_nxt = lo_r + qhi_r[31:0] - 32'd1;
          lo_nxt = lo_r + dvd_r[31:0];
          ncnt_nxt = '0; st_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (ncnt_r[5] ||
            !(((hi_r & TOP_BIT) == (lo_r & TOP_BIT)) ||
              (!hi_r[30] && lo_r[30]))) begin
          ho_nxt = hn_r; hn_nxt = sym_r;
          if (ov_r) begin
            ol_nxt = 1'b1; ret_nxt = ST_IDLE; st_nxt = ST_OUT; ov_nxt = 1'b0;
          end else st_nxt = ST_IDLE;
        end else if ((hi_r & TOP_BIT) == (lo_r & TOP_BIT)) begin
          if (ov_r) begin
            ol_nxt = 1'b0; ret_nxt = ST_NORM; st_nxt = ST_OUT; ov_nxt = 1'b0;
          end else begin
            od_nxt = pack(OK_RUN, hi_r[31], pend_r, '0, '0, 1'b0);
            ph_nxt = ph_r + 3'd1 + pend_r[2:0];
            ov_nxt = 1'b1; pend_nxt = '0;
            lo_nxt = lo_r << 1; hi_nxt = {hi_r[30:0], 1'b1};
            ncnt_nxt = ncnt_r + 6'd1;
          end
        end else begin
          pend_nxt = pend_inc;
          lo_nxt = {1'b0, lo_r[29:0], 1'b0};
          hi_nxt = {1'b1, hi_r[29:0], 1'b1};
          ncnt_nxt = ncnt_r + 6'd1;
        end
      end
      ST_OUT: begin
        if (out_tready) st_nxt = ret_r;
      end
      ST_FLUSH_PAD: begin
        od_nxt = pack(OK_PAD, 1'b0, '0, '0, 3'd0 - ph_r, 1'b0);
        ol_nxt = 1'b1; ret_nxt = ST_IDLE; st_nxt = ST_OUT;
        lo_nxt = '0; hi_nxt = '1; pend_nxt = '0; ho_nxt = '0; hn_nxt = '0;
        raw_nxt = '0; ph_nxt = '0;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; clr_r <= '0; lo_r <= '0; hi_r <= '1; pend_r <= '0;
      ho_r <= '0; hn_r <= '0; raw_r <= '0; ph_r <= '0; ov_r <= 1'b0;
      ret_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
      pend_r <= pend_nxt; ho_r <= ho_nxt; hn_r <= hn_nxt; raw_r <= raw_nxt;
      ph_r <= ph_nxt; ov_r <= ov_nxt; ret_r <= ret_nxt;
    end
    sym_r <= sym_nxt; idx_r <= idx_nxt; below_r <= below_nxt; tot_r <= tot_nxt;
    own_r <= own_nxt; rdcnt_r <= rdcnt_nxt; pass_r <= pass_nxt; dvd_r <= dvd_nxt;
    rem_r <= rem_nxt; dcnt_r <= dcnt_nxt; qhi_r <= qhi_nxt; ncnt_r <= ncnt_nxt;
    od_r <= od_nxt; ol_r <= ol_nxt;
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");
  a_raw_max: assert property (@(posedge clk) disable iff (!rst_n)
    raw_r <= 2'd2) else $error("raw count overrun");
  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_NORM |-> ncnt_r <= 6'd32) else $error("renorm overrun");
`endif
endmodule
`default_nettype wire
